FILE: rtl/sacu_pkg.sv
// Shared types and constants for the steering angle calibration unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package sacu_pkg;

  // Operation selector carried in tuser
  localparam logic [1:0] OP_ANGLE  = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  // Calibration phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LEFT   = 2'd1;
  localparam logic [1:0] PH_RIGHT  = 2'd2;
  localparam logic [1:0] PH_CENTER = 2'd3;

  // Configuration register indexes
  localparam logic CFG_DEBOUNCE   = 1'b0;
  localparam logic CFG_LONG_PRESS = 1'b1;

  localparam int DebW      = 20;
  localparam int LongW     = 24;
  localparam int CalW      = 32;
  localparam int FullScale = 127;
  localparam int QuoW      = 7;
  localparam int MagW      = CalW + 1;
  localparam int NumW      = MagW + QuoW;

  localparam logic [CalW-1:0] LEFT_RESET  = -32'sd20480;
  localparam logic [CalW-1:0] RIGHT_RESET = 32'sd20480;

  // Commands from controller to datapath
  typedef struct packed {
    logic       in_load;
    logic       unwrap;
    logic       diff;
    logic       sel;
    logic       mul;
    logic       div_step;
    logic [2:0] div_idx;
    logic       btn_edge;
    logic       btn_hold;
    logic       btn_apply;
    logic       stop_load;
    logic       out_load;
  } sacu_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       absent;
    logic       need_div;
  } sacu_sts_t;

endpackage
`default_nettype wire

FILE: rtl/steering_angle_calibration_unit.sv
// Angle sample: dispatch, unwrap, difference, side select, scale, serial divider when
// needed, result load. Button poll: edge, hold, apply; load: stop load; absent sensor or
// other op: straight to result load. One item at a time: the next word is taken in the
// cycle after the result is loaded; a stalled result holds the next one back.
// Reset (rst_ni low, asynchronous) restores default stops, idle phase, default timing.
// Depends on sacu_pkg, sacu_ctrl and sacu_dp.
`default_nettype none
module steering_angle_calibration_unit import sacu_pkg::*; #(
  parameter int ANGLE_BITS = 14,
  parameter int TIME_BITS  = 48
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  // raw_angle[14:0], button_level_pressed, now_us, load_left, load_right, load_center
  input  wire [((112+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  wire [1:0]               s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  // steer_value, calibrating, hid_button, save_strobe, cal_phase,
  // cal_left_out, cal_right_out, cal_center_out
  output logic [111:0]            m_axis_tdata,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire                     cfg_index_i,
  input  wire [LongW-1:0]         cfg_data_i
);

  localparam int TB = TIME_BITS;

  sacu_cmd_t cmd;
  sacu_sts_t sts;
  logic [7:0]      steer;
  logic            cal, hid, save;
  logic [1:0]      ph;
  logic [CalW-1:0] lo, ro, co;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, co, ro, lo, ph, save, hid, cal, steer};

  sacu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sacu_dp #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (s_axis_tuser),
    .raw_angle_i   (s_axis_tdata[14:0]),
    .btn_i         (s_axis_tdata[15]),
    .now_i         (s_axis_tdata[16 +: TB]),
    .load_left_i   (s_axis_tdata[16+TB +: CalW]),
    .load_right_i  (s_axis_tdata[48+TB +: CalW]),
    .load_center_i (s_axis_tdata[80+TB +: CalW]),
    .steer_o       (steer),
    .calibrating_o (cal),
    .hid_o         (hid),
    .save_o        (save),
    .phase_o       (ph),
    .left_o        (lo),
    .right_o       (ro),
    .center_o      (co)
  );

endmodule
`default_nettype wire

FILE: rtl/sacu_ctrl.sv
// Sequencing state machine of the steering angle calibration unit.
// Depends on sacu_pkg; drives the datapath through sacu_cmd_t.
`default_nettype none
module sacu_ctrl import sacu_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  sacu_sts_t  sts_i,
  output sacu_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UNWRAP = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_SEL    = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_EDGE   = 4'd6;
  localparam logic [3:0] S_HOLD   = 4'd7;
  localparam logic [3:0] S_APPLY  = 4'd8;
  localparam logic [3:0] S_LOAD   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_DISP   = 4'd11;

  logic [3:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       oval_q, oval_d;
  logic       accept, out_free;
  logic [3:0] first_st;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !oval_q || out_ready_i;

  // Dispatch on the operation once the word is captured
  always_comb begin
    case (sts_i.op)
      OP_ANGLE:  first_st = sts_i.absent ? S_FIN : S_UNWRAP;
      OP_BUTTON: first_st = S_EDGE;
      OP_LOAD:   first_st = S_LOAD;
      default:   first_st = S_FIN;
    endcase
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.div_idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.in_load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = first_st;
      end
      S_UNWRAP: begin
        cmd_o.unwrap = 1'b1;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (sts_i.need_div) begin
          cmd_o.mul = 1'b1;
          idx_d = 3'(QuoW - 1);
          state_d = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        idx_d = idx_q - 3'd1;
        if (idx_q == 3'd0) state_d = S_FIN;
      end
      S_EDGE: begin
        cmd_o.btn_edge = 1'b1;
        state_d = S_HOLD;
      end
      S_HOLD: begin
        cmd_o.btn_hold = 1'b1;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.btn_apply = 1'b1;
        state_d = S_FIN;
      end
      S_LOAD: begin
        cmd_o.stop_load = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop on take
  always_comb begin
    oval_d = oval_q;
    if (oval_q && out_ready_i) oval_d = 1'b0;
    if (cmd_o.out_load) oval_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      oval_q  <= oval_d;
      idx_q   <= idx_d;
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sacu_dp.sv
// Datapath of the steering angle calibration unit: unwrap, span mapping with
// a serial divider, button debounce and calibration state. Depends on sacu_pkg.
`default_nettype none
module sacu_dp import sacu_pkg::*; #(
  parameter int ANGLE_BITS = 14,
  parameter int TIME_BITS  = 48
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  sacu_cmd_t             cmd_i,
  output sacu_sts_t             sts_o,
  input  wire                   cfg_we_i,
  input  wire                   cfg_index_i,
  input  wire [LongW-1:0]       cfg_data_i,
  input  wire [1:0]             op_i,
  input  wire [14:0]            raw_angle_i,
  input  wire                   btn_i,
  input  wire [TIME_BITS-1:0]   now_i,
  input  wire [CalW-1:0]        load_left_i,
  input  wire [CalW-1:0]        load_right_i,
  input  wire [CalW-1:0]        load_center_i,
  output logic [7:0]            steer_o,
  output logic                  calibrating_o,
  output logic                  hid_o,
  output logic                  save_o,
  output logic [1:0]            phase_o,
  output logic [CalW-1:0]       left_o,
  output logic [CalW-1:0]       right_o,
  output logic [CalW-1:0]       center_o
);

  localparam int AB = ANGLE_BITS;
  localparam int TB = TIME_BITS;
  localparam int TW = CalW - AB;

  // Captured input word
  logic [1:0]      op_q;
  logic [14:0]     raw_in_q;
  logic            btn_q;
  logic [TB-1:0]   now_q;
  logic [CalW-1:0] ld_l_q, ld_r_q, ld_c_q;

  // Persistent state
  logic [AB-1:0]   prev_q, origin_q;
  logic [TW-1:0]   turn_q;
  logic            have_q;
  logic [CalW-1:0] cont_q, left_q, right_q, center_q;
  logic [1:0]      phase_q;
  logic            stable_q, last_lvl_q, used_q, strobe_q;
  logic [TB-1:0]   press_q, rchg_q;
  logic [DebW-1:0] deb_q;
  logic [LongW-1:0] long_q;

  // Working registers
  logic signed [MagW-1:0] dc_q, dl_q, dr_q;
  logic [MagW-1:0] a_q, b_q;
  logic [NumW-1:0] num_q;
  logic [QuoW-1:0] quo_q;
  logic            neg_q, need_q, deb_ok_q, hold_ok_q;

  assign sts_o.op       = op_q;
  assign sts_o.absent   = raw_in_q[14];
  assign sts_o.need_div = need_q;

  // Unwrap
  logic [15:0]       raw16;
  logic [AB-1:0]     raw, prev_e, org_e;
  logic signed [AB:0] diff;
  logic [TW-1:0]     turn_n;
  logic [CalW-1:0]   cont_n;
  assign raw16  = {1'b0, raw_in_q};
  assign raw    = raw16[AB-1:0];
  assign prev_e = have_q ? prev_q : raw;
  assign org_e  = have_q ? origin_q : raw;
  assign diff   = $signed({1'b0, raw}) - $signed({1'b0, prev_e});
  always_comb begin
    turn_n = turn_q;
    if (diff < -$signed((AB+1)'(1 << (AB-1))))     turn_n = turn_q + TW'(1);
    else if (diff > $signed((AB+1)'(1 << (AB-1)))) turn_n = turn_q - TW'(1);
  end
  assign cont_n = {turn_n, {AB{1'b0}}} + CalW'(raw) - CalW'(org_e);

  // Side selection
  logic [MagW-1:0] mag_dc, mag_dl, mag_dr, b_sel;
  logic            use_l, zero_r, neg_s;
  assign mag_dc = dc_q[MagW-1] ? MagW'(-dc_q) : MagW'(dc_q);
  assign mag_dl = dl_q[MagW-1] ? MagW'(-dl_q) : MagW'(dl_q);
  assign mag_dr = dr_q[MagW-1] ? MagW'(-dr_q) : MagW'(dr_q);
  always_comb begin
    use_l  = (dl_q != '0) && (dc_q[MagW-1] == dl_q[MagW-1]);
    zero_r = (dc_q == '0) || (!use_l && ((dr_q == '0) || (dc_q[MagW-1] != dr_q[MagW-1])));
    b_sel  = use_l ? mag_dl : mag_dr;
    neg_s  = use_l;
  end

  // Divider step
  logic [NumW-1:0] bsh;
  logic [NumW:0]   trial;
  assign bsh   = NumW'(b_q) << cmd_i.div_idx;
  assign trial = {1'b0, num_q} - {1'b0, bsh};

  // Button timing
  logic          chg;
  logic [TB-1:0] rchg_n, deb_el, hold_el;
  assign chg     = btn_q != last_lvl_q;
  assign rchg_n  = chg ? now_q : rchg_q;
  assign deb_el  = now_q - rchg_n;
  assign hold_el = now_q - press_q;

  // Short and long press effects on phase and stops
  logic [1:0]      ph_s, ph_l;
  assign ph_l = (phase_q == PH_IDLE) ? PH_LEFT : PH_IDLE;
  always_comb begin
    case (phase_q)
      PH_LEFT:   ph_s = PH_RIGHT;
      PH_RIGHT:  ph_s = PH_CENTER;
      PH_CENTER: ph_s = PH_IDLE;
      default:   ph_s = PH_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0; origin_q <= '0; turn_q <= '0; have_q <= 1'b0;
      cont_q <= '0; left_q <= LEFT_RESET; right_q <= RIGHT_RESET; center_q <= '0;
      phase_q <= PH_IDLE; stable_q <= 1'b0; last_lvl_q <= 1'b0; used_q <= 1'b0;
      strobe_q <= 1'b0; press_q <= '0; rchg_q <= '0;
      deb_q <= DebW'(40000); long_q <= LongW'(1500000);
      op_q <= '0; raw_in_q <= '0; need_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DEBOUNCE) deb_q <= cfg_data_i[DebW-1:0];
        else                             long_q <= cfg_data_i;
      end
      if (cmd_i.in_load) begin
        op_q <= op_i; raw_in_q <= raw_angle_i; strobe_q <= 1'b0; need_q <= 1'b0;
      end
      if (cmd_i.unwrap) begin
        prev_q <= raw; origin_q <= org_e; have_q <= 1'b1;
        turn_q <= turn_n; cont_q <= cont_n;
      end
      if (cmd_i.sel) need_q <= !zero_r && (mag_dc < b_sel);
      if (cmd_i.btn_edge) begin
        last_lvl_q <= btn_q; rchg_q <= rchg_n;
      end
      if (cmd_i.btn_apply && deb_ok_q) begin
        if (btn_q != stable_q) begin
          stable_q <= btn_q;
          if (btn_q) begin
            press_q <= now_q; used_q <= 1'b0;
          end else if (!used_q) begin
            if (hold_ok_q) begin
              phase_q <= ph_l;
            end else begin
              phase_q <= ph_s;
              if (phase_q == PH_LEFT)   left_q <= cont_q;
              if (phase_q == PH_RIGHT)  right_q <= cont_q;
              if (phase_q == PH_CENTER) begin
                center_q <= cont_q; strobe_q <= 1'b1;
              end
            end
          end
        end else if (stable_q && !used_q && hold_ok_q) begin
          phase_q <= ph_l; used_q <= 1'b1;
        end
      end
      if (cmd_i.stop_load) begin
        left_q <= ld_l_q; right_q <= ld_r_q; center_q <= ld_c_q;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      btn_q <= btn_i; now_q <= now_i;
      ld_l_q <= load_left_i; ld_r_q <= load_right_i; ld_c_q <= load_center_i;
      quo_q <= '0; neg_q <= 1'b0;
    end
    if (cmd_i.diff) begin
      dc_q <= $signed({cont_q[CalW-1], cont_q}) - $signed({center_q[CalW-1], center_q});
      dl_q <= $signed({left_q[CalW-1], left_q}) - $signed({center_q[CalW-1], center_q});
      dr_q <= $signed({right_q[CalW-1], right_q}) - $signed({center_q[CalW-1], center_q});
    end
    if (cmd_i.sel) begin
      a_q   <= mag_dc;
      b_q   <= b_sel;
      neg_q <= !zero_r && neg_s;
      quo_q <= (zero_r || (mag_dc < b_sel)) ? '0 : QuoW'(FullScale);
    end
    // Scale by 127 as a shift and subtract
    if (cmd_i.mul) num_q <= {a_q, {QuoW{1'b0}}} - NumW'(a_q);
    // Restoring division, one quotient bit a step
    if (cmd_i.div_step && !trial[NumW]) begin
      num_q <= trial[NumW-1:0];
      quo_q[cmd_i.div_idx] <= 1'b1;
    end
    if (cmd_i.btn_edge) deb_ok_q <= deb_el >= TB'(deb_q);
    if (cmd_i.btn_hold) hold_ok_q <= hold_el >= TB'(long_q);
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      steer_o       <= neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
      calibrating_o <= phase_q != PH_IDLE;
      hid_o         <= (phase_q == PH_IDLE) && stable_q;
      save_o        <= strobe_q;
      phase_o       <= phase_q;
      left_o        <= left_q;
      right_o       <= right_q;
      center_o      <= center_q;
    end
  end

endmodule
`default_nettype wire
